// ===== hdl/ptq_pkg.sv =====
// Package for the priority transmit queue: sizes, command codes and transaction types.
package ptq_pkg;

  localparam int QUEUE_DEPTH      = 16;
  localparam int MAX_PACKET_BYTES = 255;

  localparam int CMD_W    = 2;
  localparam int PRIO_W   = 3;
  localparam int NUM_PRIO = 1 << PRIO_W;
  localparam int LEN_IN_W = 10;
  localparam int LEN_W    = 8;
  localparam int LEFT_W   = 5;
  localparam int OVF_W    = 16;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [PRIO_W-1:0]   prio_in;
    logic [LEN_IN_W-1:0] len_in;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic [PRIO_W-1:0] prio_out;
    logic [LEN_W-1:0]  len_out;
    logic [LEFT_W-1:0] entries_left;
    logic [OVF_W-1:0]  overflows;
  } out_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [LEN_W-1:0]  len;
  } entry_t;

  typedef struct packed {
    logic occupied;
    logic load_new;
    logic deq;
  } cell_ctrl_t;

endpackage

// ===== hdl/ptq_cell.sv =====
// One queue slot: holds an entry, joins the oldest-best search chain, shifts toward the head.
module ptq_cell
  import ptq_pkg::*;
(
  input  logic                clk_i,
  input  cell_ctrl_t          ctrl_i,
  input  logic [PRIO_W-1:0]   min_prio_i,
  input  entry_t              new_entry_i,
  input  entry_t              next_entry_i,
  input  logic                hit_i,
  output entry_t              entry_o,
  output logic                hit_o,
  output logic [NUM_PRIO-1:0] class_o,
  output entry_t              sel_entry_o
);

  entry_t entry_q, entry_d;
  logic   match;

  // Flag own priority class so the row can find the lowest class present.
  assign class_o = ctrl_i.occupied ? (NUM_PRIO'(1) << entry_q.prio) : '0;

  // First matching cell from the head is the winner; it and everything younger shift.
  assign match       = ctrl_i.occupied && (entry_q.prio == min_prio_i);
  assign hit_o       = hit_i | match;
  assign sel_entry_o = (match && !hit_i) ? entry_q : '0;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load_new) begin
      entry_d = new_entry_i;
    end else if (ctrl_i.deq && hit_o) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== hdl/priority_tx_queue_top.sv =====
// Top level of the priority transmit queue: handshakes, counters and the row of slot cells.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------
//   in      | input     | in_valid_i / in_stall_o | in_data_i  (cmd, prio_in, len_in)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (ok, prio_out, len_out,
//           |           |                         |   entries_left, overflows)
//
// Each command is accepted at a clock edge and its result sits in the output register
// right after. The clock period is set by the search ripple through the row of cells
// (class compare, lowest-class pick, then the first-match chain and shift).
// Reset clears the fill count, the overflow count and the output valid; slot contents
// are not reset and are only read below the fill count.
// The input stalls only while a result waits in the output register and the output is
// stalled; a result leaving frees the register for a new transaction in the same cycle.
module priority_tx_queue_top
  import ptq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic [CNT_W-1:0] fill_q, fill_d;
  logic [OVF_W-1:0] ovf_q, ovf_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  logic accept;
  logic is_enq, is_deq;
  logic full, empty;

  entry_t                new_entry;
  logic [LEN_IN_W-1:0]   len_sat;
  logic [PRIO_W-1:0]     min_prio;
  logic [NUM_PRIO-1:0]   class_any;
  entry_t                sel_entry;
  logic [31:0]           left_wide;

  cell_ctrl_t          cell_ctrl  [QUEUE_DEPTH];
  entry_t              cell_entry [QUEUE_DEPTH];
  entry_t              cell_next  [QUEUE_DEPTH];
  entry_t              cell_sel   [QUEUE_DEPTH];
  logic [NUM_PRIO-1:0] cell_class [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0] hit_chain;

  // Accept a transaction whenever the output register is free or being emptied.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_enq     = accept && (cmd_e'(in_data_i.cmd) == CMD_ENQUEUE);
  assign is_deq     = accept && (cmd_e'(in_data_i.cmd) == CMD_DEQUEUE);

  assign full  = (fill_q >= CNT_W'(QUEUE_DEPTH));
  assign empty = (fill_q == '0);

  // Saturate the length, keep the stored width.
  assign len_sat = (in_data_i.len_in > LEN_IN_W'(MAX_PACKET_BYTES))
                 ? LEN_IN_W'(MAX_PACKET_BYTES) : in_data_i.len_in;
  assign new_entry.prio = in_data_i.prio_in;
  assign new_entry.len  = len_sat[LEN_W-1:0];

  // Row of cells; the head (index 0) holds the oldest entry.
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign cell_ctrl[i].occupied = (CNT_W'(i) < fill_q);
    assign cell_ctrl[i].load_new = is_enq && !full && (fill_q == CNT_W'(i));
    assign cell_ctrl[i].deq      = is_deq;

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign cell_next[i] = cell_entry[i];
    end else begin : g_body
      assign cell_next[i] = cell_entry[i+1];
    end

    ptq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl[i]),
      .min_prio_i   (min_prio),
      .new_entry_i  (new_entry),
      .next_entry_i (cell_next[i]),
      .hit_i        (hit_chain[i]),
      .entry_o      (cell_entry[i]),
      .hit_o        (hit_chain[i+1]),
      .class_o      (cell_class[i]),
      .sel_entry_o  (cell_sel[i])
    );
  end

  // Gather the classes present and the winning entry (at most one cell drives it).
  always_comb begin
    class_any = '0;
    sel_entry = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      class_any = class_any | cell_class[i];
      sel_entry = sel_entry | cell_sel[i];
    end
  end

  // Lowest priority number present.
  always_comb begin
    min_prio = '0;
    for (int p = NUM_PRIO - 1; p >= 0; p--) begin
      if (class_any[p]) begin
        min_prio = PRIO_W'(p);
      end
    end
  end

  // Counters and result.
  always_comb begin
    fill_d       = fill_q;
    ovf_d        = ovf_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    left_wide    = '0;
    if (accept) begin
      out_d.ok       = 1'b0;
      out_d.prio_out = '0;
      out_d.len_out  = '0;
      unique case (in_data_i.cmd)
        CMD_ENQUEUE: begin
          if (full) begin
            ovf_d = ovf_q + OVF_W'(1);
          end else begin
            fill_d   = fill_q + CNT_W'(1);
            out_d.ok = 1'b1;
          end
        end
        CMD_DEQUEUE: begin
          if (!empty) begin
            fill_d         = fill_q - CNT_W'(1);
            out_d.ok       = 1'b1;
            out_d.prio_out = sel_entry.prio;
            out_d.len_out  = sel_entry.len;
          end
        end
        CMD_CLEAR: begin
          fill_d = '0;
        end
        default: begin
          // reserved code: report counts, change nothing
        end
      endcase
      left_wide          = 32'(fill_d);
      out_d.entries_left = left_wide[LEFT_W-1:0];
      out_d.overflows    = ovf_d;
      out_valid_d        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      ovf_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the priority transmit queue: random and directed commands.
`timescale 1ns / 100ps

module tb;
  import ptq_pkg::*;

  // The package names only three commands; the fourth code must do nothing.
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  // Cycles with no transaction on either side before the run is called hung. The slowest
  // legal stretch is a sender gap plus a receiver stall plus a drain pause, all well below.
  localparam int unsigned HANG_LIMIT = 1000;
  localparam int unsigned RANDOM_CMDS = 1800;
  localparam int unsigned MAX_IDLE = 19;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_PRINTED = 40;

  typedef struct {
    in_t         cmd_word;
    int unsigned gap;          // idle cycles before this command is offered
    bit          drain_first;  // hold until every pending result has been taken
  } planned_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  priority_tx_queue_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Shadow copy of the queue: slots in arrival order, oldest at index zero.
  entry_t          shadow_slots [QUEUE_DEPTH];
  int unsigned     shadow_fill = 0;
  logic [OVF_W-1:0] shadow_overflows = '0;

  planned_cmd_t cmd_backlog [$];
  out_t         expected_results [$];

  int unsigned planned_total = 0;
  int unsigned cmds_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned refused_enqueues = 0;
  int unsigned empty_dequeues = 0;
  int unsigned full_hits = 0;
  int unsigned sender_calm = 0;
  int unsigned receiver_calm = 0;

  // 4 ns clock.
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Apply one command to the shadow queue and return the result the block must give.
  function automatic out_t serve_command(in_t c);
    out_t r;
    int unsigned best;
    r = '0;
    case (c.cmd)
      CMD_ENQUEUE: begin
        if (shadow_fill >= QUEUE_DEPTH) begin
          // Full: refuse the entry and bump the wrapping overflow count.
          shadow_overflows = shadow_overflows + 1'b1;
          refused_enqueues++;
        end else begin
          shadow_slots[shadow_fill].prio = c.prio_in;
          shadow_slots[shadow_fill].len  = (c.len_in > LEN_IN_W'(MAX_PACKET_BYTES)) ?
                                           LEN_W'(MAX_PACKET_BYTES) : c.len_in[LEN_W-1:0];
          shadow_fill++;
          if (shadow_fill == QUEUE_DEPTH) full_hits++;
          r.ok = 1'b1;
        end
      end
      CMD_DEQUEUE: begin
        if (shadow_fill > 0) begin
          // Strict less-than keeps the oldest entry among equal priorities.
          best = 0;
          for (int unsigned i = 1; i < shadow_fill; i++) begin
            if (shadow_slots[i].prio < shadow_slots[best].prio) best = i;
          end
          r.ok       = 1'b1;
          r.prio_out = shadow_slots[best].prio;
          r.len_out  = shadow_slots[best].len;
          // Close the gap, keeping arrival order of the younger entries.
          for (int unsigned i = best; i + 1 < shadow_fill; i++) begin
            shadow_slots[i] = shadow_slots[i + 1];
          end
          shadow_fill--;
        end else begin
          empty_dequeues++;
        end
      end
      CMD_CLEAR: begin
        shadow_fill = 0;
      end
      default: begin
      end
    endcase
    r.entries_left = LEFT_W'(shadow_fill);
    r.overflows    = shadow_overflows;
    return r;
  endfunction

  // Queue one command for the driver. Gaps are drawn at random up to MAX_IDLE, with occasional
  // back-to-back stretches so the block also sees one command per clock when not stalled.
  task automatic plan_cmd(logic [CMD_W-1:0] cmd, logic [PRIO_W-1:0] prio,
                          logic [LEN_IN_W-1:0] len, bit drain_first);
    planned_cmd_t p;
    p.cmd_word.cmd     = cmd;
    p.cmd_word.prio_in = prio;
    p.cmd_word.len_in  = len;
    p.drain_first      = drain_first;
    if (sender_calm > 0) begin
      sender_calm--;
      p.gap = 0;
    end else if ($urandom_range(0, 24) == 0) begin
      sender_calm = $urandom_range(20, 60);
      p.gap = 0;
    end else begin
      p.gap = $urandom_range(0, MAX_IDLE);
    end
    cmd_backlog.push_back(p);
    planned_total++;
  endtask

  // Random length, leaning on the saturation boundary and the field extremes.
  function automatic logic [LEN_IN_W-1:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return LEN_IN_W'(MAX_PACKET_BYTES);
      3:       return LEN_IN_W'(MAX_PACKET_BYTES + 1);
      default: return LEN_IN_W'($urandom_range(0, (1 << LEN_IN_W) - 1));
    endcase
  endfunction

  // Driver: predict each accepted command, then offer the next one after its gap.
  int unsigned idle_run = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      idle_run   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(serve_command(in_data_i));
        cmds_accepted++;
      end
      // A stalled command stays on the bus unchanged; otherwise load the next one.
      if (!in_valid_i || !in_stall_o) begin
        if (cmd_backlog.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (idle_run < cmd_backlog[0].gap) begin
          idle_run   <= idle_run + 1;
          in_valid_i <= 1'b0;
        end else if (cmd_backlog[0].drain_first && expected_results.size() != 0) begin
          // Hold off until the block has handed back every pending result.
          in_valid_i <= 1'b0;
        end else begin
          in_data_i  <= cmd_backlog[0].cmd_word;
          in_valid_i <= 1'b1;
          idle_run   <= 0;
          void'(cmd_backlog.pop_front());
        end
      end
    end
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatch_count < MAX_PRINTED) begin
      $display("%0t: result %0d: %s is %0d, expected %0d", $realtime, results_checked,
               what, got, want);
    end
    mismatch_count++;
  endtask

  // Monitor: stall at random, and check each result against the oldest prediction.
  int unsigned stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    int unsigned next_stall;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending, ok", out_data_o.ok, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.ok !== want.ok)
            report_mismatch("ok", out_data_o.ok, want.ok);
          if (out_data_o.prio_out !== want.prio_out)
            report_mismatch("prio_out", out_data_o.prio_out, want.prio_out);
          if (out_data_o.len_out !== want.len_out)
            report_mismatch("len_out", out_data_o.len_out, want.len_out);
          if (out_data_o.entries_left !== want.entries_left)
            report_mismatch("entries_left", out_data_o.entries_left, want.entries_left);
          if (out_data_o.overflows !== want.overflows)
            report_mismatch("overflows", out_data_o.overflows, want.overflows);
        end
        results_checked++;
        // Draw the stall for the next result, with runs of zero-stall results.
        if (receiver_calm > 0) begin
          receiver_calm--;
          next_stall = 0;
        end else if ($urandom_range(0, 24) == 0) begin
          receiver_calm = $urandom_range(20, 60);
          next_stall = 0;
        end else begin
          next_stall = $urandom_range(0, MAX_IDLE);
        end
        stall_left  <= next_stall;
        out_stall_i <= (next_stall != 0);
      end else if (stall_left > 0) begin
        // Count down every cycle, so stalls also overlap cycles with no result.
        stall_left  <= stall_left - 1;
        out_stall_i <= (stall_left > 1);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d commands accepted, %0d pending",
                 $realtime, HANG_LIMIT, cmds_accepted, expected_results.size());
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus plan, reset, and end of run.
  initial begin
    int unsigned mode;
    int unsigned run_len;
    int unsigned roll;
    logic [CMD_W-1:0] c;

    // Empty queue: dequeue fails, clear and the unused code report no change.
    plan_cmd(CMD_DEQUEUE, '1, '1, 1'b0);
    plan_cmd(CMD_CLEAR, '0, '0, 1'b0);
    plan_cmd(CMD_RESERVED, '1, '1, 1'b0);
    // Fill to the brim with repeating priorities so ties occur, lengths at the edges.
    for (int unsigned i = 0; i < QUEUE_DEPTH; i++) begin
      case (i)
        0:       plan_cmd(CMD_ENQUEUE, PRIO_W'(7), '1, 1'b0);
        1:       plan_cmd(CMD_ENQUEUE, PRIO_W'(0), '0, 1'b0);
        2:       plan_cmd(CMD_ENQUEUE, PRIO_W'(7), LEN_IN_W'(MAX_PACKET_BYTES), 1'b0);
        3:       plan_cmd(CMD_ENQUEUE, PRIO_W'(0), LEN_IN_W'(MAX_PACKET_BYTES + 1), 1'b0);
        default: plan_cmd(CMD_ENQUEUE, PRIO_W'((i * 5) % NUM_PRIO), LEN_IN_W'(i * 61), 1'b0);
      endcase
    end
    // Full queue refuses; the unused code must not disturb a full queue either.
    plan_cmd(CMD_ENQUEUE, '1, '1, 1'b0);
    plan_cmd(CMD_RESERVED, '0, '0, 1'b0);
    plan_cmd(CMD_ENQUEUE, '0, '0, 1'b0);
    // Take the three priority-zero entries, oldest first.
    plan_cmd(CMD_DEQUEUE, '0, '0, 1'b0);
    plan_cmd(CMD_DEQUEUE, '0, '0, 1'b0);
    plan_cmd(CMD_DEQUEUE, '0, '0, 1'b0);
    plan_cmd(CMD_CLEAR, '1, '1, 1'b0);
    // Pause the sender here until every result is back.
    plan_cmd(CMD_DEQUEUE, '0, '0, 1'b1);

    // Random phases biased toward filling, draining or a mix, so the queue swings
    // between full and empty; clears and the unused code are sprinkled in.
    while (planned_total < RANDOM_CMDS + 25) begin
      mode    = $urandom_range(0, 2);
      run_len = $urandom_range(10, 60);
      for (int unsigned k = 0; k < run_len; k++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          0:       c = (roll < 80) ? CMD_ENQUEUE : CMD_DEQUEUE;
          1:       c = (roll < 25) ? CMD_ENQUEUE : CMD_DEQUEUE;
          default: c = (roll < 50) ? CMD_ENQUEUE : CMD_DEQUEUE;
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 2) c = CMD_CLEAR;
        else if (roll < 4) c = CMD_RESERVED;
        plan_cmd(c, PRIO_W'($urandom_range(0, NUM_PRIO - 1)), pick_length(),
                 $urandom_range(0, 199) == 0);
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all commands to be taken, all results to be checked, then settle.
    while (cmds_accepted != planned_total) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    while (expected_results.size() != 0) begin
      void'(expected_results.pop_front());
      report_mismatch("missing result, count", 0, 1);
    end

    $display("Run covered %0d commands and %0d checked results, %0d mismatches.",
             cmds_accepted, results_checked, mismatch_count);
    $display("Queue filled %0d times, %0d enqueues refused, %0d dequeues on empty.",
             full_hits, refused_enqueues, empty_dequeues);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
